@@ rtl/core/pll_divider_search_defines.svh @@
// Assertion macros shared by the divider search RTL.
`ifndef PLL_DIVIDER_SEARCH_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pds_pkg.sv @@
// Types, constants and helpers for the PLL divider search.
package pds_pkg;

  localparam int DIV_DW = 40;
  localparam int DIV_RW = 32;
  localparam int DIV_CW = 6;

  localparam logic [31:0] TARGET_FLOOR = 32'd24000000;
  localparam logic [4:0]  I_LAST       = 5'd19;
  localparam logic [4:0]  I_MOD_WRAP   = 5'd16;
  localparam logic [13:0] D_LAST       = 14'd9999;
  localparam logic [19:0] D_SCALE      = 20'd10000;
  localparam logic [24:0] MCLK_RESET   = 25'd12288000;
  localparam logic [24:0] MCLK_MIN     = 25'd10000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TGT,
    OP_BYP_DIV,
    OP_BYP_SET,
    OP_IP_DIV,
    OP_IP_INIT,
    OP_IJ_STEP,
    OP_FU_DIV,
    OP_FU_SET,
    OP_FM_MUL,
    OP_FA_DIV,
    OP_FA_SET,
    OP_FB_DIV,
    OP_FB_SET,
    OP_FC_MUL,
    OP_FD_DIV,
    OP_FD_EVAL,
    OP_NEXT_P
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TGT, S_BYP, S_BYPW, S_IP, S_IPW, S_IJ,
    S_FU, S_FUW, S_FM, S_FA, S_FAW, S_FB, S_FBW, S_FC, S_FD, S_FDW, S_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic tgt_done;
    logic rate_zero;
    logic rem_zero;
    logic int_hit;
    logic j_last;
    logic p_last;
    logic j_ok;
    logic frac_hit;
    logic mclk_small;
  } dp_stat_t;

  function automatic logic [31:0] pds_dist(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ rtl/core/pds_div.sv @@
// Restoring divider, one quotient bit per cycle.
`include "pll_divider_search_defines.svh"
module pds_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pds_pkg::DIV_DW-1:0] dividend,
  input  logic [pds_pkg::DIV_RW-1:0] divisor,
  output logic                       done,
  output logic [pds_pkg::DIV_DW-1:0] quotient,
  output logic [pds_pkg::DIV_RW-1:0] remainder
);
  import pds_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_RW-1:0] dvs;
  logic [DIV_RW:0]   shifted;
  logic              fits;

  assign shifted = {remainder, quotient[DIV_DW-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= DIV_RW'(shifted - {1'b0, dvs});
        quotient  <= {quotient[DIV_DW-2:0], 1'b1};
      end else begin
        remainder <= shifted[DIV_RW-1:0];
        quotient  <= {quotient[DIV_DW-2:0], 1'b0};
      end
    end
  end

  `PDS_ASSERT_NOW(a_no_restart, start, !busy, "divider started while busy")
  `PDS_ASSERT_NEXT(a_done_pulse, done, !done, "divider done held over two cycles")
  `PDS_ASSERT_NOW(a_done_idle, done, !busy, "divider done while still busy")

endmodule

@@ rtl/core/pds_dp.sv @@
// Datapath: target search, candidate arithmetic and best-candidate registers.
module pds_dp #(
  parameter int P_MAX = 64,
  parameter int J_MAX = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [24:0]       master_clock_hz,
  input  logic [17:0]       sample_rate_hz,
  input  pds_pkg::dp_cmd_t  cmd,
  output pds_pkg::dp_stat_t stat,
  output logic              pll_bypassed,
  output logic [7:0]        n_divide,
  output logic [5:0]        p_divide,
  output logic [5:0]        j_multiply,
  output logic [13:0]       d_fraction,
  output logic [6:0]        modulator_divide,
  output logic              divider_too_high
);
  import pds_pkg::*;

  logic [24:0] mclk;
  logic [17:0] rate;
  logic [31:0] target;
  logic [4:0]  i;
  logic [6:0]  p;
  logic [5:0]  j;
  logic [24:0] q0;
  logic [6:0]  r0;
  logic [31:0] cq;
  logic [6:0]  cr;
  logic [31:0] best_dist;
  logic [6:0]  bp;
  logic [5:0]  bj;
  logic [13:0] bd;
  logic        bypass;
  logic [7:0]  n;
  logic [11:0] unit;
  logic [38:0] prod;
  logic [24:0] rr;
  logic [5:0]  jf;
  logic [13:0] df;
  logic [19:0] jd;
  logic [31:0] prod2;

  logic              div_start;
  logic [DIV_DW-1:0] div_dvd;
  logic [DIV_RW-1:0] div_dvs;
  logic              div_done;
  logic [DIV_DW-1:0] div_quo;
  logic [DIV_RW-1:0] div_rem;

  logic [31:0] rate_step;
  logic [7:0]  cr_sum;
  logic [31:0] int_dist;
  logic [31:0] frac_dist;
  logic [13:0] d_sat;

  assign rate_step = {5'b0, rate, 9'b0};
  assign cr_sum    = {1'b0, cr} + {1'b0, r0};
  assign int_dist  = pds_dist(target, cq);
  assign frac_dist = pds_dist(target, div_quo[31:0]);
  assign d_sat     = (div_quo > DIV_DW'(D_LAST)) ? D_LAST : div_quo[13:0];

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (cmd.op)
      OP_BYP_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_DW'(mclk);
        div_dvs   = target;
      end
      OP_IP_DIV, OP_FD_DIV: begin
        div_start = 1'b1;
        div_dvd   = (cmd.op == OP_IP_DIV) ? DIV_DW'(mclk) : DIV_DW'(prod2);
        div_dvs   = DIV_RW'(p);
      end
      OP_FU_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_DW'(mclk);
        div_dvs   = DIV_RW'(D_SCALE);
      end
      OP_FA_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_DW'(prod);
        div_dvs   = DIV_RW'(mclk);
      end
      OP_FB_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_DW'(rr);
        div_dvs   = DIV_RW'(unit);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pds_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mclk <= MCLK_RESET;
    end else if (cfg_wen) begin
      mclk <= master_clock_hz;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        rate   <= sample_rate_hz;
        target <= {5'b0, sample_rate_hz, 9'b0};
        i      <= 5'd1;
        p      <= 7'd1;
        bp     <= 7'd1;
        bj     <= 6'd1;
        bd     <= '0;
        bypass <= 1'b0;
        n      <= 8'd1;
      end
      OP_TGT: begin
        target <= target + rate_step;
        i      <= i + 1'b1;
      end
      OP_BYP_DIV: begin
        best_dist <= target;
      end
      OP_BYP_SET: begin
        bypass <= 1'b1;
        n      <= (div_quo > DIV_DW'(255)) ? 8'd255 : div_quo[7:0];
      end
      OP_IP_INIT: begin
        q0 <= div_quo[24:0];
        r0 <= div_rem[6:0];
        cq <= {7'b0, div_quo[24:0]};
        cr <= div_rem[6:0];
        j  <= 6'd1;
      end
      OP_IJ_STEP: begin
        if (int_dist < best_dist) begin
          best_dist <= int_dist;
          bp        <= p;
          bj        <= j;
        end
        j <= j + 1'b1;
        if (cr_sum >= {1'b0, p}) begin
          cr <= 7'(cr_sum - {1'b0, p});
          cq <= cq + {7'b0, q0} + 32'd1;
        end else begin
          cr <= cr_sum[6:0];
          cq <= cq + {7'b0, q0};
        end
        if (stat.j_last) begin
          p <= p + 1'b1;
        end
      end
      OP_FU_SET: begin
        unit <= div_quo[11:0];
        p    <= 7'd1;
      end
      OP_FM_MUL: begin
        prod <= 39'(target) * 39'(p);
      end
      OP_FA_SET: begin
        rr <= div_rem[24:0];
        jf <= div_quo[5:0];
      end
      OP_FB_SET: begin
        df <= d_sat;
        jd <= 20'(jf) * D_SCALE + 20'(d_sat);
      end
      OP_FC_MUL: begin
        prod2 <= 32'(unit) * 32'(jd);
      end
      OP_FD_EVAL: begin
        if (frac_dist < best_dist) begin
          best_dist <= frac_dist;
          bp        <= p;
          bj        <= jf;
          bd        <= df;
        end
        p <= p + 1'b1;
      end
      OP_NEXT_P: begin
        p <= p + 1'b1;
      end
      default: begin
        p <= p;
      end
    endcase
  end

  assign stat.div_done   = div_done;
  assign stat.tgt_done   = (target > TARGET_FLOOR) || (i == I_LAST);
  assign stat.rate_zero  = (rate == '0);
  assign stat.rem_zero   = (div_rem == '0);
  assign stat.int_hit    = (cq == target);
  assign stat.j_last     = (j == 6'(J_MAX));
  assign stat.p_last     = (p == 7'(P_MAX));
  assign stat.j_ok       = (div_quo != '0) && (div_quo <= DIV_DW'(J_MAX));
  assign stat.frac_hit   = (div_quo == DIV_DW'(target));
  assign stat.mclk_small = (mclk < MCLK_MIN);

  assign pll_bypassed     = !stat.rate_zero && bypass;
  assign n_divide         = stat.rate_zero ? 8'd0 : n;
  assign p_divide         = stat.rate_zero ? 6'd0 : bp[5:0];
  assign j_multiply       = stat.rate_zero ? 6'd0 : bj;
  assign d_fraction       = stat.rate_zero ? 14'd0 : bd;
  assign modulator_divide = (stat.rate_zero || i >= I_MOD_WRAP) ? 7'd0 : {i[3:0], 3'b000};
  assign divider_too_high = !stat.rate_zero && (i > I_MOD_WRAP);

endmodule

@@ rtl/core/pds_ctrl.sv @@
// Controller: sequences target search, bypass check, integer and fractional passes.
`include "pll_divider_search_defines.svh"
module pds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pds_pkg::dp_stat_t stat,
  output pds_pkg::dp_cmd_t  cmd
);
  import pds_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_TGT;
        end
      end
      S_TGT: begin
        if (stat.tgt_done) begin
          state_next = stat.rate_zero ? S_OUT : S_BYP;
        end else begin
          cmd.op = OP_TGT;
        end
      end
      S_BYP: begin
        cmd.op     = OP_BYP_DIV;
        state_next = S_BYPW;
      end
      S_BYPW: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            cmd.op     = OP_BYP_SET;
            state_next = S_OUT;
          end else begin
            state_next = S_IP;
          end
        end
      end
      S_IP: begin
        cmd.op     = OP_IP_DIV;
        state_next = S_IPW;
      end
      S_IPW: begin
        if (stat.div_done) begin
          cmd.op     = OP_IP_INIT;
          state_next = S_IJ;
        end
      end
      S_IJ: begin
        cmd.op = OP_IJ_STEP;
        priority if (stat.int_hit) begin
          state_next = S_OUT;
        end else if (stat.j_last) begin
          state_next = stat.p_last ? S_FU : S_IP;
        end
      end
      S_FU: begin
        if (stat.mclk_small) begin
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_FU_DIV;
          state_next = S_FUW;
        end
      end
      S_FUW: begin
        if (stat.div_done) begin
          cmd.op     = OP_FU_SET;
          state_next = S_FM;
        end
      end
      S_FM: begin
        cmd.op     = OP_FM_MUL;
        state_next = S_FA;
      end
      S_FA: begin
        cmd.op     = OP_FA_DIV;
        state_next = S_FAW;
      end
      S_FAW: begin
        if (stat.div_done) begin
          if (stat.j_ok) begin
            cmd.op     = OP_FA_SET;
            state_next = S_FB;
          end else begin
            cmd.op     = OP_NEXT_P;
            state_next = stat.p_last ? S_OUT : S_FM;
          end
        end
      end
      S_FB: begin
        cmd.op     = OP_FB_DIV;
        state_next = S_FBW;
      end
      S_FBW: begin
        if (stat.div_done) begin
          cmd.op     = OP_FB_SET;
          state_next = S_FC;
        end
      end
      S_FC: begin
        cmd.op     = OP_FC_MUL;
        state_next = S_FD;
      end
      S_FD: begin
        cmd.op     = OP_FD_DIV;
        state_next = S_FDW;
      end
      S_FDW: begin
        if (stat.div_done) begin
          cmd.op     = OP_FD_EVAL;
          state_next = (stat.frac_hit || stat.p_last) ? S_OUT : S_FM;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `PDS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second beat taken in flight")
  `PDS_ASSERT_NOW(a_out_blocks_in, out_valid, !in_ready, "input open while result pending")

endmodule

@@ rtl/core/pll_divider_search.sv @@
// Top level of the PLL divider search: controller, datapath and config register.
// One request at a time. A request runs the target clock search and the bypass check,
// then an integer pass (per P value, one divide plus one step per J) and a fractional
// pass (per P value, three divides), ending early on an exact match or in bypass.
// All divides share the single bit-serial divider.
module pll_divider_search #(
  parameter int P_MAX = 64,
  parameter int J_MAX = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [24:0] master_clock_hz,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [17:0] sample_rate_hz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pll_bypassed,
  output logic [7:0]  n_divide,
  output logic [5:0]  p_divide,
  output logic [5:0]  j_multiply,
  output logic [13:0] d_fraction,
  output logic [6:0]  modulator_divide,
  output logic        divider_too_high
);
  import pds_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pds_dp #(
    .P_MAX (P_MAX),
    .J_MAX (J_MAX)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wen          (cfg_wen),
    .master_clock_hz  (master_clock_hz),
    .sample_rate_hz   (sample_rate_hz),
    .cmd              (cmd),
    .stat             (stat),
    .pll_bypassed     (pll_bypassed),
    .n_divide         (n_divide),
    .p_divide         (p_divide),
    .j_multiply       (j_multiply),
    .d_fraction       (d_fraction),
    .modulator_divide (modulator_divide),
    .divider_too_high (divider_too_high)
  );

endmodule

@@ tb/tb_pll_divider_search.sv @@
// Testbench for pll_divider_search: directed and random sample rates checked against a predictor.
class divider_scoreboard;
  typedef struct packed {
    logic        bypassed;
    logic [7:0]  n;
    logic [5:0]  p;
    logic [5:0]  j;
    logic [13:0] d;
    logic [6:0]  mdiv;
    logic        too_high;
  } setting_t;

  setting_t pending[$];
  int errors;
  int checked;

  function automatic longint unsigned gap(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic setting_t search(logic [24:0] mclk_in, logic [17:0] rate_in);
    setting_t s;
    longint unsigned mclk, rate, target, i, c, unit, d, jj, best;
    int bp, bj;
    longint unsigned bd;
    bit done;
    mclk = mclk_in;
    rate = rate_in;
    s = '0;
    if (rate == 0) return s;
    bp = 1; bj = 1; bd = 0; best = 0; done = 0;
    for (i = 1; i <= 19; i++) begin
      target = rate * 512 * i;
      if (target > 24000000) break;
    end
    if (i > 19) i = 19;
    s.n = 1;
    if (mclk == 0 || mclk % target == 0) begin
      s.bypassed = 1;
      c = (mclk == 0) ? 0 : mclk / target;
      s.n = (c > 255) ? 8'd255 : c[7:0];
    end else begin
      for (int p = 1; p <= 64 && !done; p++) begin
        for (int j = 1; j <= 63; j++) begin
          c = mclk * j / p;
          if (gap(target, c) < gap(target, best)) begin
            bj = j; bp = p; best = c;
          end
          if (c == target) begin
            done = 1;
            break;
          end
        end
      end
      if (!done && mclk / 10000 != 0) begin
        unit = mclk / 10000;
        for (int p = 1; p <= 64; p++) begin
          jj = target * p / mclk;
          if (jj < 1 || jj > 63) continue;
          d = (target * p - mclk * jj) / unit;
          if (d > 9999) d = 9999;
          c = unit * (jj * 10000 + d) / p;
          if (gap(target, c) < gap(target, best)) begin
            bj = jj; bp = p; bd = d; best = c;
          end
          if (c == target) break;
        end
      end
    end
    s.p = bp[5:0];
    s.j = bj[5:0];
    s.d = bd[13:0];
    c = target / (rate * 64);
    if (c > 128) s.too_high = 1;
    else if (c < 128) s.mdiv = c[6:0];
    return s;
  endfunction

  function void note_request(logic [24:0] mclk, logic [17:0] rate);
    pending.push_back(search(mclk, rate));
  endfunction

  function void check_result(setting_t got);
    setting_t want;
    checked++;
    if (pending.size() == 0) begin
      report("unexpected result beat", 0, 0);
      return;
    end
    want = pending.pop_front();
    if (got.bypassed != want.bypassed) report("pll_bypassed", got.bypassed, want.bypassed);
    if (got.n != want.n) report("n_divide", got.n, want.n);
    if (got.p != want.p) report("p_divide", got.p, want.p);
    if (got.j != want.j) report("j_multiply", got.j, want.j);
    if (got.d != want.d) report("d_fraction", got.d, want.d);
    if (got.mdiv != want.mdiv) report("modulator_divide", got.mdiv, want.mdiv);
    if (got.too_high != want.too_high) report("divider_too_high", got.too_high, want.too_high);
  endfunction

  function void report(string what, int got, int want);
    errors++;
    $display("mismatch on result %0d: %s got %0d want %0d", checked, what, got, want);
  endfunction
endclass

module tb_pll_divider_search;
  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wen = 0;
  logic [24:0] master_clock_hz = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [17:0] sample_rate_hz = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        pll_bypassed;
  logic [7:0]  n_divide;
  logic [5:0]  p_divide;
  logic [5:0]  j_multiply;
  logic [13:0] d_fraction;
  logic [6:0]  modulator_divide;
  logic        divider_too_high;

  divider_scoreboard board = new();
  logic [24:0] mclk_now = 25'd12288000;
  int sent = 0;
  int hold_cycles = 0;
  bit stall_req = 0;
  bit stall_taken = 0;

  pll_divider_search DUT (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .master_clock_hz(master_clock_hz),
    .in_valid(in_valid), .in_ready(in_ready), .sample_rate_hz(sample_rate_hz),
    .out_valid(out_valid), .out_ready(out_ready), .pll_bypassed(pll_bypassed),
    .n_divide(n_divide), .p_divide(p_divide), .j_multiply(j_multiply),
    .d_fraction(d_fraction), .modulator_divide(modulator_divide),
    .divider_too_high(divider_too_high)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_request(mclk_now, sample_rate_hz);
    if (!rst && out_valid && out_ready)
      board.check_result({pll_bypassed, n_divide, p_divide, j_multiply, d_fraction,
                          modulator_divide, divider_too_high});
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (stall_req && !stall_taken) begin
      stall_taken <= 1;
      hold_cycles <= 3000;
      out_ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 15) == 0) hold_cycles <= pick_gap();
    end
  end

  task automatic send_rate(logic [17:0] rate);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_valid <= 0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1;
    sample_rate_hz <= rate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_mclk(logic [24:0] value);
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wen <= 1;
    master_clock_hz <= value;
    @(posedge clk);
    cfg_wen <= 0;
    mclk_now = value;
  endtask

  function automatic logic [17:0] random_rate();
    int k;
    logic [17:0] common[8] = '{18'd8000, 18'd11025, 18'd16000, 18'd22050, 18'd32000,
                               18'd44100, 18'd48000, 18'd96000};
    k = $urandom_range(0, 9);
    if (k < 6) return common[$urandom_range(0, 7)];
    if (k < 9) return 18'($urandom_range(8000, 192000));
    return 18'($urandom());
  endfunction

  initial begin
    logic [24:0] mclks[6] = '{25'd12288000, 25'd10000, 25'd30000000, 25'd11289600,
                              25'd0, 25'h1FFFFFF};
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (mclks[m]) begin
      if (m != 0) write_mclk(mclks[m]);
      send_rate(18'd8000);
      send_rate(18'd48000);
      send_rate(18'd192000);
      send_rate(18'd44100);
      if (m == 0) begin
        send_rate(18'd0);
        send_rate(18'h3FFFF);
        send_rate(18'd1);
        send_rate(18'd2);
        send_rate(18'h15555);
        send_rate(18'h2AAAA);
        stall_req = 1;
        send_rate(18'd96000);
        send_rate(18'd32000);
        send_rate(18'd16000);
      end
      for (int r = 0; r < 12; r++) send_rate(random_rate());
    end
    write_mclk(25'($urandom_range(10000, 30000000)));
    for (int r = 0; r < 6; r++) send_rate(random_rate());
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests over %0d master clock settings, %0d results checked",
             sent, 7, board.checked);
    if (board.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #200000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pds_pkg.sv
rtl/core/pds_div.sv
rtl/core/pds_dp.sv
rtl/core/pds_ctrl.sv
rtl/core/pll_divider_search.sv
tb/tb_pll_divider_search.sv
